### rtl/btlv_pkg.sv
package btlv_pkg;

  // Parser phases, one-hot
  typedef enum logic [4:0] {
    PH_TAG     = 5'b00001,
    PH_LEN     = 5'b00010,
    PH_LBYTES  = 5'b00100,
    PH_CONTENT = 5'b01000,
    PH_SKIP    = 5'b10000
  } btlv_phase_t;

  // Result status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_TRUNC    = 2'd1;
  localparam logic [1:0] ST_LEN_LONG = 2'd2;
  localparam logic [1:0] ST_TOO_FEW  = 2'd3;

  localparam logic [7:0] NULL_TAG  = 8'h00;
  localparam logic [3:0] DONE_SAT  = 4'd15;

  // Result queue: each entry holds what one byte produced (one or two results)
  localparam int QDEPTH = 2;
  localparam int QAW    = $clog2(QDEPTH);
  localparam int QCW    = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic [7:0]  tag_value;
    logic [31:0] content_length;
    logic [2:0]  header_length;
    logic [31:0] start_offset;
    logic [1:0]  status;
    logic        end_of_run;
  } btlv_res_t;

  typedef struct packed {
    logic      two;
    btlv_res_t r0;
    btlv_res_t r1;
  } btlv_entry_t;

  function automatic btlv_res_t mk_res(input logic [7:0] tag, input logic [31:0] clen,
                                       input logic [2:0] hlen, input logic [31:0] start,
                                       input logic [1:0] status);
    btlv_res_t r;
    r.tag_value      = tag;
    r.content_length = clen;
    r.header_length  = hlen;
    r.start_offset   = start;
    r.status         = status;
    r.end_of_run     = 1'b0;
    return r;
  endfunction

endpackage

### rtl/ber_tlv_sequence_parser.sv
// A result is queued when the byte that causes it is accepted, then leaves on the out_ ports.
// One byte per cycle while in_stall is low; parser state updates in a single pass per byte.
// A byte ending a buffer can cause two results; the output side then presents them on two
// consecutive transactions, and in_stall rises only while the two-entry result queue is full.
// Reset (rst_n low at a clock edge) clears the parser and queue and sets objects_wanted to 1.
module ber_tlv_sequence_parser #(
  parameter int MAX_LENGTH_BYTES = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  // configuration
  input  logic        cfg_write_en,
  input  logic [3:0]  cfg_objects_wanted,
  // byte input
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_byte,
  // result output
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_tag_value,
  output logic [31:0] out_content_length,
  output logic [2:0]  out_header_length,
  output logic [31:0] out_start_offset,
  output logic [1:0]  out_status,
  output logic        out_end_of_run
);

  // Width of the long-form length byte counter
  localparam int LBW = $clog2(MAX_LENGTH_BYTES + 1);

  // Parser state
  logic [3:0]           cfg_r;
  btlv_pkg::btlv_phase_t phase_r, phase_nxt;
  logic [7:0]           tag_r, tag_nxt;
  logic [31:0]          acc_r, acc_nxt;
  logic [LBW-1:0]       lbl_r, lbl_nxt;
  logic [31:0]          cl_r, cl_nxt;
  logic [31:0]          pos_r, pos_nxt;
  logic [31:0]          start_r, start_nxt;
  logic [3:0]           done_r, done_nxt;

  // Result queue
  btlv_pkg::btlv_entry_t     q_r [btlv_pkg::QDEPTH];
  logic [btlv_pkg::QAW-1:0]  wr_ptr_r, rd_ptr_r;
  logic [btlv_pkg::QCW-1:0]  cnt_r, cnt_nxt;
  logic                      sel_r;

  logic                  in_acc, out_acc, push, pop;
  logic [3:0]            wanted;
  logic                  main_v, last_v;
  btlv_pkg::btlv_res_t   main_res, last_res;
  btlv_pkg::btlv_entry_t new_entry, head;
  btlv_pkg::btlv_res_t   head_res;
  logic [6:0]            len_k;
  logic [31:0]           cl_dec;
  logic [3:0]            done_inc;
  logic [LBW-1:0]        lbl_dec;

  assign in_stall = (cnt_r == btlv_pkg::QCW'(btlv_pkg::QDEPTH));
  assign in_acc   = in_valid && !in_stall;
  assign out_acc  = out_valid && !out_stall;

  // A register value of zero counts as one wanted object
  assign wanted   = (cfg_r == 4'd0) ? 4'd1 : cfg_r;
  assign len_k    = in_data_byte[6:0];
  assign cl_dec   = cl_r - 32'd1;
  assign lbl_dec  = lbl_r - LBW'(1);
  // Finished-object count saturates
  assign done_inc = (done_r < btlv_pkg::DONE_SAT) ? done_r + 4'd1 : done_r;

  // Per-byte parse step
  always_comb begin
    phase_nxt = phase_r;
    tag_nxt   = tag_r;
    acc_nxt   = acc_r;
    lbl_nxt   = lbl_r;
    cl_nxt    = cl_r;
    start_nxt = start_r;
    done_nxt  = done_r;
    main_v    = 1'b0;
    main_res  = btlv_pkg::mk_res(8'd0, 32'd0, 3'd0, 32'd0, btlv_pkg::ST_OK);
    last_v    = 1'b0;
    last_res  = btlv_pkg::mk_res(8'd0, 32'd0, 3'd0, 32'd0, btlv_pkg::ST_TOO_FEW);

    case (phase_r)
      btlv_pkg::PH_TAG: begin
        if (done_r >= wanted) begin
          // register was lowered below the count already reached
          phase_nxt = btlv_pkg::PH_SKIP;
        end else begin
          start_nxt = pos_r;
          tag_nxt   = in_data_byte;
          acc_nxt   = 32'd0;
          if (in_data_byte == btlv_pkg::NULL_TAG) begin
            // null tag: no length byte, finish at once
            main_v    = 1'b1;
            main_res  = btlv_pkg::mk_res(btlv_pkg::NULL_TAG, 32'd0, 3'd1, pos_r,
                                         btlv_pkg::ST_OK);
            done_nxt  = done_inc;
            phase_nxt = (done_inc >= wanted) ? btlv_pkg::PH_SKIP : btlv_pkg::PH_TAG;
          end else begin
            phase_nxt = btlv_pkg::PH_LEN;
          end
        end
      end
      btlv_pkg::PH_LEN: begin
        acc_nxt = 32'd0;
        if (in_data_byte[7] && (len_k > 7'(MAX_LENGTH_BYTES))) begin
          // long form with too many length bytes
          main_v    = 1'b1;
          main_res  = btlv_pkg::mk_res(tag_r, 32'd0, 3'd0, start_r, btlv_pkg::ST_LEN_LONG);
          phase_nxt = btlv_pkg::PH_SKIP;
        end else if (in_data_byte[7] && (len_k != 7'd0)) begin
          lbl_nxt   = len_k[LBW-1:0];
          phase_nxt = btlv_pkg::PH_LBYTES;
        end else if (in_data_byte[7] || (in_data_byte == 8'd0)) begin
          // zero content: finish on this byte (bare 0x80 counts as length zero)
          main_v    = 1'b1;
          main_res  = btlv_pkg::mk_res(tag_r, 32'd0, pos_r[2:0] + 3'd1 - start_r[2:0],
                                       start_r, btlv_pkg::ST_OK);
          done_nxt  = done_inc;
          phase_nxt = (done_inc >= wanted) ? btlv_pkg::PH_SKIP : btlv_pkg::PH_TAG;
        end else begin
          acc_nxt   = {24'd0, in_data_byte};
          cl_nxt    = {24'd0, in_data_byte};
          phase_nxt = btlv_pkg::PH_CONTENT;
        end
      end
      btlv_pkg::PH_LBYTES: begin
        if (acc_r[31:24] != 8'd0) begin
          // length value would overflow 32 bits
          main_v    = 1'b1;
          main_res  = btlv_pkg::mk_res(tag_r, 32'd0, 3'd0, start_r, btlv_pkg::ST_LEN_LONG);
          phase_nxt = btlv_pkg::PH_SKIP;
        end else begin
          acc_nxt = {acc_r[23:0], in_data_byte};
          lbl_nxt = lbl_dec;
          if (lbl_dec == '0) begin
            if ({acc_r[23:0], in_data_byte} == 32'd0) begin
              main_v    = 1'b1;
              main_res  = btlv_pkg::mk_res(tag_r, 32'd0, pos_r[2:0] + 3'd1 - start_r[2:0],
                                           start_r, btlv_pkg::ST_OK);
              done_nxt  = done_inc;
              phase_nxt = (done_inc >= wanted) ? btlv_pkg::PH_SKIP : btlv_pkg::PH_TAG;
            end else begin
              cl_nxt    = {acc_r[23:0], in_data_byte};
              phase_nxt = btlv_pkg::PH_CONTENT;
            end
          end
        end
      end
      btlv_pkg::PH_CONTENT: begin
        cl_nxt = cl_dec;
        if (cl_dec == 32'd0) begin
          main_v    = 1'b1;
          main_res  = btlv_pkg::mk_res(tag_r, acc_r,
                                       pos_r[2:0] + 3'd1 - start_r[2:0] - acc_r[2:0],
                                       start_r, btlv_pkg::ST_OK);
          done_nxt  = done_inc;
          phase_nxt = (done_inc >= wanted) ? btlv_pkg::PH_SKIP : btlv_pkg::PH_TAG;
        end
      end
      btlv_pkg::PH_SKIP: begin
        // drop bytes until the end of the buffer
      end
      default: begin
        phase_nxt = btlv_pkg::PH_SKIP;
      end
    endcase

    if (in_last_byte) begin
      // end of buffer: report a cut-off object or a short sequence, then restart
      if (phase_nxt inside {btlv_pkg::PH_LEN, btlv_pkg::PH_LBYTES, btlv_pkg::PH_CONTENT}) begin
        last_v   = 1'b1;
        last_res = btlv_pkg::mk_res(tag_nxt, 32'd0, 3'd0, start_nxt, btlv_pkg::ST_TRUNC);
      end else if ((phase_nxt == btlv_pkg::PH_TAG) && (done_nxt < wanted)) begin
        last_v   = 1'b1;
        last_res = btlv_pkg::mk_res(8'd0, 32'd0, 3'd0, 32'd0, btlv_pkg::ST_TOO_FEW);
      end
      phase_nxt = btlv_pkg::PH_TAG;
      done_nxt  = 4'd0;
      acc_nxt   = 32'd0;
      lbl_nxt   = '0;
      cl_nxt    = 32'd0;
      pos_nxt   = 32'd0;
    end else begin
      pos_nxt   = pos_r + 32'd1;
    end
  end

  // Pack this byte's results; end_of_run marks the last one
  always_comb begin
    new_entry     = '0;
    new_entry.two = main_v && last_v;
    if (main_v) begin
      new_entry.r0            = main_res;
      new_entry.r0.end_of_run = !last_v;
      new_entry.r1            = last_res;
      new_entry.r1.end_of_run = 1'b1;
    end else begin
      new_entry.r0            = last_res;
      new_entry.r0.end_of_run = 1'b1;
    end
  end

  assign push = in_acc && (main_v || last_v);

  // Output side: walk the head entry one result per transaction
  assign head      = q_r[rd_ptr_r];
  assign head_res  = sel_r ? head.r1 : head.r0;
  assign out_valid = (cnt_r != '0);
  assign pop       = out_acc && (sel_r || !head.two);

  assign out_tag_value      = head_res.tag_value;
  assign out_content_length = head_res.content_length;
  assign out_header_length  = head_res.header_length;
  assign out_start_offset   = head_res.start_offset;
  assign out_status         = head_res.status;
  assign out_end_of_run     = head_res.end_of_run;

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + btlv_pkg::QCW'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - btlv_pkg::QCW'(1);
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r    <= 4'd1;
      phase_r  <= btlv_pkg::PH_TAG;
      tag_r    <= 8'd0;
      acc_r    <= 32'd0;
      lbl_r    <= '0;
      cl_r     <= 32'd0;
      pos_r    <= 32'd0;
      start_r  <= 32'd0;
      done_r   <= 4'd0;
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
      sel_r    <= 1'b0;
    end else begin
      if (cfg_write_en) begin
        cfg_r <= cfg_objects_wanted;
      end
      if (in_acc) begin
        phase_r <= phase_nxt;
        tag_r   <= tag_nxt;
        acc_r   <= acc_nxt;
        lbl_r   <= lbl_nxt;
        cl_r    <= cl_nxt;
        pos_r   <= pos_nxt;
        start_r <= start_nxt;
        done_r  <= done_nxt;
      end
      if (push) begin
        wr_ptr_r <= wr_ptr_r + btlv_pkg::QAW'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + btlv_pkg::QAW'(1);
      end
      cnt_r <= cnt_nxt;
      if (out_acc) begin
        // advance to the second result of a two-result entry, else back to the first
        sel_r <= !pop;
      end
    end
  end

  // Queue storage, no reset needed
  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= new_entry;
    end
  end

  // Checks
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= btlv_pkg::QCW'(btlv_pkg::QDEPTH))
    else $error("result queue overfilled");

  a_sel_two: assert property (@(posedge clk) disable iff (!rst_n)
    sel_r |-> (out_valid && head.two))
    else $error("second result selected in a single-result entry");

  a_last_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_last_byte) |=> (phase_r == btlv_pkg::PH_TAG && done_r == 4'd0 &&
                                  pos_r == 32'd0))
    else $error("parser not restarted after end of buffer");

  a_content_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == btlv_pkg::PH_CONTENT) |-> (cl_r != 32'd0))
    else $error("content phase with no content left");

  a_last_eor: assert property (@(posedge clk) disable iff (!rst_n)
    push |=> (q_r[$past(wr_ptr_r)].two ? q_r[$past(wr_ptr_r)].r1.end_of_run
                                       : q_r[$past(wr_ptr_r)].r0.end_of_run))
    else $error("stored entry lacks end_of_run on its last result");

endmodule

### sim/ber_tlv_sequence_parser_tb.sv
`timescale 1ns / 1ps

module ber_tlv_sequence_parser_tb;

  localparam int MAX_LEN_BYTES = 4;
  localparam int CLK_PERIOD    = 20;
  localparam int ITEM_TARGET   = 550;
  localparam int HOLD_CYCLES   = 150;
  localparam int LIMIT_NS      = 5_000_000;

  // Receiver stall behavior
  typedef enum logic [1:0] {
    RX_FREE,
    RX_RANDOM,
    RX_PATTERN
  } rx_mode_t;

  logic        clk;
  logic        rst_n              = 1'b0;
  logic        cfg_write_en       = 1'b0;
  logic [3:0]  cfg_objects_wanted = 4'd0;
  logic        in_valid           = 1'b0;
  logic        in_stall;
  logic [7:0]  in_data_byte       = 8'h00;
  logic        in_last_byte       = 1'b0;
  logic        out_valid;
  logic        out_stall          = 1'b0;
  logic [7:0]  out_tag_value;
  logic [31:0] out_content_length;
  logic [2:0]  out_header_length;
  logic [31:0] out_start_offset;
  logic [1:0]  out_status;
  logic        out_end_of_run;

  ber_tlv_sequence_parser #(
    .MAX_LENGTH_BYTES(MAX_LEN_BYTES)
  ) dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_write_en       (cfg_write_en),
    .cfg_objects_wanted (cfg_objects_wanted),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_data_byte       (in_data_byte),
    .in_last_byte       (in_last_byte),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_tag_value      (out_tag_value),
    .out_content_length (out_content_length),
    .out_header_length  (out_header_length),
    .out_start_offset   (out_start_offset),
    .out_status         (out_status),
    .out_end_of_run     (out_end_of_run)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // Hard stop in case the block hangs or never drains
  initial begin
    #(LIMIT_NS);
    $display("Verification failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Parser prediction: mirrors the byte-by-byte TLV walk, state at reset values
  // ---------------------------------------------------------------------------
  btlv_pkg::btlv_phase_t parse_phase = btlv_pkg::PH_TAG;
  logic [7:0]  parse_tag   = 8'h00;
  logic [31:0] len_acc     = 32'd0;
  logic [6:0]  len_left    = 7'd0;
  logic [31:0] body_left   = 32'd0;
  logic [31:0] byte_pos    = 32'd0;
  logic [31:0] obj_start   = 32'd0;
  logic [3:0]  objs_done   = 4'd0;
  logic [3:0]  wanted_reg  = 4'd1;

  btlv_pkg::btlv_res_t byte_results[$];     // results raised by the byte being predicted
  btlv_pkg::btlv_res_t expected_results[$]; // results still owed by the block

  // Bookkeeping
  int errors          = 0;
  int bytes_sent      = 0;
  int buffers_sent    = 0;
  int results_checked = 0;
  int status_seen[4]  = '{0, 0, 0, 0};

  // Sender and receiver idling
  bit        gaps_on      = 1'b1;
  int        burst_left   = 0;
  rx_mode_t  rx_mode      = RX_RANDOM;
  logic      hold_request = 1'b0;
  bit        hold_taken   = 1'b0;
  int        hold_left    = 0;
  int        rx_tick      = 0;

  logic [7:0] frame[$];           // bytes of the buffer being assembled

  function automatic logic [3:0] wanted_now();
    return (wanted_reg == 4'd0) ? 4'd1 : wanted_reg;
  endfunction

  function automatic void note_result(logic [7:0] tag, logic [31:0] clen, logic [2:0] hlen,
                                      logic [31:0] start, logic [1:0] st);
    btlv_pkg::btlv_res_t r;
    r.tag_value      = tag;
    r.content_length = clen;
    r.header_length  = hlen;
    r.start_offset   = start;
    r.status         = st;
    r.end_of_run     = 1'b0;
    byte_results.push_back(r);
  endfunction

  function automatic void finish_object();
    if (objs_done < btlv_pkg::DONE_SAT)
      objs_done = objs_done + 4'd1;
    if (objs_done >= wanted_now())
      parse_phase = btlv_pkg::PH_SKIP;
    else
      parse_phase = btlv_pkg::PH_TAG;
  endfunction

  // Header complete: a zero length finishes the object right here
  function automatic void header_done(logic [31:0] pos);
    logic [31:0] span;
    if (len_acc == 32'd0) begin
      span = pos + 32'd1 - obj_start;
      note_result(parse_tag, 32'd0, span[2:0], obj_start, btlv_pkg::ST_OK);
      finish_object();
    end else begin
      body_left   = len_acc;
      parse_phase = btlv_pkg::PH_CONTENT;
    end
  endfunction

  function automatic void length_error();
    note_result(parse_tag, 32'd0, 3'd0, obj_start, btlv_pkg::ST_LEN_LONG);
    parse_phase = btlv_pkg::PH_SKIP;
  endfunction

  // Advance the parser by one accepted byte and queue what it should produce
  function automatic void predict_tlv_results(logic [7:0] b, logic last);
    logic [31:0] pos;
    logic [31:0] span;
    logic [6:0]  nlen;
    pos = byte_pos;
    byte_results.delete();
    case (parse_phase)
      btlv_pkg::PH_TAG: begin
        if (objs_done >= wanted_now()) begin
          parse_phase = btlv_pkg::PH_SKIP;
        end else begin
          obj_start = pos;
          parse_tag = b;
          len_acc   = 32'd0;
          if (b == btlv_pkg::NULL_TAG) begin
            note_result(btlv_pkg::NULL_TAG, 32'd0, 3'd1, pos, btlv_pkg::ST_OK);
            finish_object();
          end else begin
            parse_phase = btlv_pkg::PH_LEN;
          end
        end
      end
      btlv_pkg::PH_LEN: begin
        len_acc = 32'd0;
        nlen    = b[6:0];
        if (b[7]) begin
          if (nlen > MAX_LEN_BYTES) begin
            length_error();
          end else if (nlen == 7'd0) begin
            header_done(pos);
          end else begin
            len_left    = nlen;
            parse_phase = btlv_pkg::PH_LBYTES;
          end
        end else begin
          len_acc = {24'd0, b};
          header_done(pos);
        end
      end
      btlv_pkg::PH_LBYTES: begin
        if (len_acc[31:24] != 8'd0) begin
          length_error();
        end else begin
          len_acc  = {len_acc[23:0], b};
          len_left = len_left - 7'd1;
          if (len_left == 7'd0)
            header_done(pos);
        end
      end
      btlv_pkg::PH_CONTENT: begin
        body_left = body_left - 32'd1;
        if (body_left == 32'd0) begin
          span = pos + 32'd1 - obj_start - len_acc;
          note_result(parse_tag, len_acc, span[2:0], obj_start, btlv_pkg::ST_OK);
          finish_object();
        end
      end
      default: begin
      end
    endcase

    // End of buffer: flag an unfinished object or a short sequence, then rewind
    if (last) begin
      if (parse_phase == btlv_pkg::PH_LEN || parse_phase == btlv_pkg::PH_LBYTES ||
          parse_phase == btlv_pkg::PH_CONTENT)
        note_result(parse_tag, 32'd0, 3'd0, obj_start, btlv_pkg::ST_TRUNC);
      else if (parse_phase == btlv_pkg::PH_TAG && objs_done < wanted_now())
        note_result(8'h00, 32'd0, 3'd0, 32'd0, btlv_pkg::ST_TOO_FEW);
      parse_phase = btlv_pkg::PH_TAG;
      objs_done   = 4'd0;
      len_acc     = 32'd0;
      len_left    = 7'd0;
      body_left   = 32'd0;
      byte_pos    = 32'd0;
    end else begin
      byte_pos = pos + 32'd1;
    end

    if (byte_results.size() != 0)
      byte_results[byte_results.size() - 1].end_of_run = 1'b1;
    foreach (byte_results[i])
      expected_results.push_back(byte_results[i]);
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: check each transaction, then pick the next stall value
  // ---------------------------------------------------------------------------
  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk) begin : result_side
    btlv_pkg::btlv_res_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result: tag %0h status %0d", out_tag_value, out_status);
        errors++;
      end else begin
        want = expected_results.pop_front();
        check_field("tag_value", 32'(want.tag_value), 32'(out_tag_value));
        check_field("content_length", want.content_length, out_content_length);
        check_field("header_length", 32'(want.header_length), 32'(out_header_length));
        check_field("start_offset", want.start_offset, out_start_offset);
        check_field("status", 32'(want.status), 32'(out_status));
        check_field("end_of_run", 32'(want.end_of_run), 32'(out_end_of_run));
        results_checked++;
        status_seen[want.status]++;
      end
    end

    // Long hold-off on request, otherwise the current stall pattern
    rx_tick++;
    if (hold_request && !hold_taken) begin
      hold_taken = 1'b1;
      hold_left  = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      case (rx_mode)
        RX_RANDOM:  out_stall <= ($urandom_range(0, 2) == 0);
        RX_PATTERN: out_stall <= ((rx_tick % 7) < 3);
        default:    out_stall <= 1'b0;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------------

  // Offer one byte, hold it until taken, then maybe drop valid for a gap
  task automatic send_byte(logic [7:0] b, logic last);
    in_valid     <= 1'b1;
    in_data_byte <= b;
    in_last_byte <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_tlv_results(b, last);
    bytes_sent++;
    if (last)
      buffers_sent++;
    if (gaps_on) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 12);
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end else begin
        burst_left--;
      end
    end
  endtask

  task automatic send_frame(bit with_last);
    int n;
    n = frame.size();
    for (int i = 0; i < n; i++)
      send_byte(frame[i], with_last && (i == n - 1));
    frame.delete();
  endtask

  // Drop valid and wait until every owed result is out, plus a little slack
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_wanted(logic [3:0] v);
    settle();
    cfg_objects_wanted <= v;
    cfg_write_en       <= 1'b1;
    @(posedge clk);
    cfg_write_en <= 1'b0;
    wanted_reg = v;
  endtask

  // Append one well-formed object: tag, length field (short or long), content
  function automatic void add_object(logic [7:0] tag, int clen, bit long_form);
    int nbytes;
    frame.push_back(tag);
    if (tag == btlv_pkg::NULL_TAG)
      return;
    if (!long_form && clen < 128) begin
      frame.push_back(8'(clen));
    end else begin
      nbytes = (clen == 0) ? 0 : (clen < 256) ? 1 : (clen < 65536) ? 2 : 3;
      nbytes = $urandom_range(nbytes, MAX_LEN_BYTES);   // leading zero bytes allowed
      frame.push_back(8'h80 | 8'(nbytes));
      for (int i = nbytes - 1; i >= 0; i--)
        frame.push_back(8'(clen >> (8 * i)));
    end
    repeat (clen) frame.push_back(8'($urandom_range(0, 255)));
  endfunction

  function automatic logic [7:0] random_tag();
    return ($urandom_range(0, 5) == 0) ? btlv_pkg::NULL_TAG : 8'($urandom_range(1, 255));
  endfunction

  // Mostly short bodies, sometimes medium, rarely past the short-form limit
  function automatic int random_clen();
    int r;
    r = $urandom_range(0, 39);
    if (r == 0)
      return $urandom_range(128, 300);
    else if (r < 8)
      return $urandom_range(7, 40);
    return $urandom_range(0, 6);
  endfunction

  task automatic random_buffer();
    int kind;
    int cut;
    kind = $urandom_range(0, 19);
    if (kind < 14) begin
      // well-formed sequence, sometimes with trailing junk or cut short
      repeat ($urandom_range(1, wanted_now() + 1))
        add_object(random_tag(), random_clen(), $urandom_range(0, 1));
      if (kind >= 10)
        repeat ($urandom_range(1, 3)) frame.push_back(8'($urandom_range(0, 255)));
      if (kind >= 12) begin
        cut = $urandom_range(1, frame.size());
        frame = frame[0:cut-1];
      end
    end else if (kind < 16) begin
      // oversized length field after up to two good objects
      repeat ($urandom_range(0, 2)) add_object(random_tag(), random_clen(), 1'b0);
      frame.push_back(8'($urandom_range(1, 255)));
      frame.push_back(8'h80 | 8'($urandom_range(MAX_LEN_BYTES + 1, 127)));
      repeat ($urandom_range(0, 3)) frame.push_back(8'($urandom_range(0, 255)));
    end else if (kind < 18) begin
      // full-width long form, usually truncated in the body
      frame.push_back(8'($urandom_range(1, 255)));
      frame.push_back(8'h84);
      repeat (4) frame.push_back(8'($urandom_range(0, 255)));
      repeat ($urandom_range(0, 5)) frame.push_back(8'($urandom_range(0, 255)));
    end else begin
      // noise
      repeat ($urandom_range(1, 16)) frame.push_back(8'($urandom_range(0, 255)));
    end
    send_frame(1'b1);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Null tag at reset setting: one object wanted, finishes on the only byte
  task automatic test_null_tag();
    frame = '{btlv_pkg::NULL_TAG};
    send_frame(1'b1);
  endtask

  // Short form, null tag, and long form with zero length bytes ending the buffer
  task automatic test_definite_lengths();
    write_wanted(4'd3);
    frame = '{8'hFF, 8'h02, 8'hAA, 8'h55, btlv_pkg::NULL_TAG, 8'h04, 8'h80};
    send_frame(1'b1);
  endtask

  // Buffer ends on a boundary short of the wanted count: ok result, then too-few
  task automatic test_too_few_objects();
    frame = '{btlv_pkg::NULL_TAG, 8'h01, 8'h01, 8'h7F};
    send_frame(1'b1);
  endtask

  // Length field with more bytes than allowed: error, rest of buffer ignored
  task automatic test_length_field_too_long();
    frame = '{8'h02, 8'h85, 8'h11};
    send_frame(1'b1);
  endtask

  // Buffer ends inside content, then a buffer ending right after a tag
  task automatic test_truncated();
    frame = '{8'h04, 8'h82, 8'h01, 8'h00, 8'hAA};
    send_frame(1'b1);
    frame = '{8'h05};
    send_frame(1'b1);
  endtask

  // Four-byte long form; raising the count after the goal was met changes nothing
  task automatic test_midbuffer_config();
    write_wanted(4'd1);
    frame = '{8'h10, 8'h84, 8'h00, 8'h00, 8'h00, 8'h01, 8'hCD};
    send_frame(1'b0);
    write_wanted(4'd4);
    frame = '{btlv_pkg::NULL_TAG};
    send_frame(1'b1);
  endtask

  // Count of zero behaves as one
  task automatic test_zero_register();
    write_wanted(4'd0);
    frame = '{btlv_pkg::NULL_TAG, btlv_pkg::NULL_TAG};
    send_frame(1'b1);
  endtask

  // Hold the result side for a long stretch while bytes keep coming, so the
  // result queue fills and the input stalls; the first buffer ends on a
  // double result
  task automatic test_backpressure();
    write_wanted(4'd15);
    gaps_on = 1'b0;
    hold_request <= 1'b1;
    repeat (12) frame.push_back(btlv_pkg::NULL_TAG);
    send_frame(1'b1);
    repeat (15) frame.push_back(btlv_pkg::NULL_TAG);
    send_frame(1'b1);
    gaps_on = 1'b1;
  endtask

  // Random buffers over several settings, extremes included
  task automatic test_random_buffers();
    int round;
    int round_start;
    round = 0;
    while (bytes_sent < ITEM_TARGET) begin
      case (round % 6)
        0:       write_wanted(4'd1);
        1:       write_wanted(4'd8);
        2:       write_wanted(4'd15);
        3:       write_wanted(4'd0);
        default: write_wanted(4'($urandom_range(1, 15)));
      endcase
      // one round runs with no idling at all
      if (round == 1) begin
        gaps_on = 1'b0;
        rx_mode <= RX_FREE;
      end else begin
        gaps_on = ($urandom_range(0, 3) != 0);
        rx_mode <= rx_mode_t'($urandom_range(0, 2));
      end
      round_start = bytes_sent;
      while (bytes_sent - round_start < 90 && bytes_sent < ITEM_TARGET)
        random_buffer();
      round++;
    end
    gaps_on = 1'b1;
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_null_tag();
    test_definite_lengths();
    test_too_few_objects();
    test_length_field_too_long();
    test_truncated();
    test_midbuffer_config();
    test_zero_register();
    test_backpressure();
    test_random_buffers();

    settle();
    repeat (10) @(posedge clk);

    $display("Parsed %0d bytes in %0d buffers, %0d results checked",
             bytes_sent, buffers_sent, results_checked);
    $display("Results by status: %0d ok, %0d truncated, %0d length too long, %0d too few",
             status_seen[btlv_pkg::ST_OK], status_seen[btlv_pkg::ST_TRUNC],
             status_seen[btlv_pkg::ST_LEN_LONG], status_seen[btlv_pkg::ST_TOO_FEW]);
    if (errors == 0 && expected_results.size() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
